### rtl/core/kst_pkg.sv
// Shared constants, types and codes for the keyed slot table.
package kst_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_EXT_W = (SLOT_W > 6) ? SLOT_W : 6;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  localparam int ID_W   = 16;
  localparam int CAT_W  = 16;
  localparam int KEY_W  = 16;
  localparam int ACT_W  = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int ENTRY_W = ID_W + CAT_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR    = 3'd0,
    ACT_ALLOC    = 3'd1,
    ACT_FIND_ID  = 3'd2,
    ACT_FIND_CAT = 3'd3,
    ACT_UPDATE   = 3'd4,
    ACT_REMOVE   = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // input transfer taken this cycle
    logic scan;    // walk the table one entry per cycle
    logic finish;  // commit the action and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic direct;    // incoming action needs no table walk
    logic scan_end;  // walk has found a match or compared the last slot
    logic out_free;  // result register can take a new result
  } stat_t;

endpackage

### rtl/core/keyed_slot_table_core.sv
// Top level of the keyed slot table: controller plus datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  in_     | in  | in_tvalid/in_tready   | action[2:0] key[18:3] category[34:19]
//  out_    | out | out_tvalid/out_tready | status[0] slot[6:1] ident[22:7]
//          |     |                    | category_out[38:23]
//
// Flow: one item at a time. Clear and unknown actions go straight from the
//   input transfer to the commit step. Every other action walks the slot store
//   through its single registered read port, one slot per cycle, and stops at
//   the first hit, or after the last slot on a miss or a full table.
// Reset: used bits and the id counter clear at once; no clearing pass, since a
//   slot's stored id and category are only read while its used bit is set.
// Stalls: the result sits in the output register; a further item is accepted
//   meanwhile and waits at its commit step until that register is taken.
module keyed_slot_table_core
  import kst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // action[2:0], key[18:3], category[34:19]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[0], slot[6:1], ident[22:7],
                                            // category_out[38:23]
);

  cmd_t  cmd;   // sequencer commands
  stat_t stat;  // datapath status

  // sequencer: idle / table walk / commit
  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot store, compare stage, id counter and result register
  kst_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

### rtl/core/kst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/kst_ctrl.sv
// Sequencer for the keyed slot table: accept, table walk, commit.
module kst_ctrl
  import kst_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = stat.direct ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/kst_dp.sv
// Datapath: slot store, used bits, id counter, compare stage and result register.
module kst_dp
  import kst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  // latched item
  act_t             op_r;
  logic [KEY_W-1:0] key_r;
  logic [CAT_W-1:0] cat_r;

  // walk pointers
  logic [SLOT_W-1:0] iss_idx_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic              cmp_vld_r;

  // walk outcome
  logic              hit_r;
  logic [SLOT_W-1:0] hit_idx_r;
  logic [ID_W-1:0]   hit_ident_r;
  logic [CAT_W-1:0]  hit_cat_r;

  // table state
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [ID_W-1:0]  ctr_r;

  // result register
  logic                  out_vld_r;
  logic                  out_status_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [ID_W-1:0]       out_ident_r;
  logic [CAT_W-1:0]      out_cat_r;

  act_t             in_act;
  logic [ENTRY_W-1:0] rdata;
  logic [ID_W-1:0]  rd_ident;
  logic [CAT_W-1:0] rd_cat;
  logic             used_c;
  logic             match;
  logic             scan_end;
  logic [ID_W-1:0]  ctr_inc;
  logic             ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_EXT_W-1:0] hit_idx_ext;

  logic                  res_status;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic [ID_W-1:0]       res_ident;
  logic [CAT_W-1:0]      res_cat;

  assign in_act   = act_t'(in_tdata[ACT_W-1:0]);
  assign rd_ident = rdata[ID_W-1:0];
  assign rd_cat   = rdata[ENTRY_W-1:ID_W];
  assign used_c   = used_r[cmp_idx_r];
  assign ctr_inc  = ctr_r + ID_W'(1);
  assign hit_idx_ext = IDX_EXT_W'(hit_idx_r);

  kst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_idx_r),
    .wdata (ram_wdata),
    .raddr (iss_idx_r),
    .rdata (rdata)
  );

  always_comb begin
    unique case (op_r)
      ACT_ALLOC:    match = !used_c;
      ACT_FIND_ID,
      ACT_UPDATE,
      ACT_REMOVE:   match = used_c && (rd_ident == key_r);
      ACT_FIND_CAT: match = used_c && (rd_cat == key_r);
      default:      match = 1'b0;
    endcase
  end

  assign scan_end = cmp_vld_r && (match || (cmp_idx_r == LAST_SLOT));

  assign stat.direct   = !((in_act == ACT_ALLOC) || (in_act == ACT_FIND_ID) ||
                           (in_act == ACT_FIND_CAT) || (in_act == ACT_UPDATE) ||
                           (in_act == ACT_REMOVE));
  assign stat.scan_end = scan_end;
  assign stat.out_free = !out_vld_r || out_tready;

  // commit: result fields, table writes
  always_comb begin
    res_status = STAT_FAIL;
    res_slot   = '0;
    res_ident  = '0;
    res_cat    = '0;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    used_nxt   = used_r;
    unique case (op_r)
      ACT_CLEAR: begin
        res_status = STAT_OK;
        used_nxt   = '0;
      end
      ACT_ALLOC: begin
        if (hit_r) begin
          res_status = STAT_OK;
          res_slot   = hit_idx_ext[SLOT_OUT_W-1:0];
          res_ident  = ctr_inc;
          res_cat    = cat_r;
          ram_we     = 1'b1;
          ram_wdata  = {cat_r, ctr_inc};
          used_nxt[hit_idx_r] = 1'b1;
        end
      end
      ACT_FIND_ID,
      ACT_FIND_CAT: begin
        if (hit_r) begin
          res_status = STAT_OK;
          res_slot   = hit_idx_ext[SLOT_OUT_W-1:0];
          res_ident  = hit_ident_r;
          res_cat    = hit_cat_r;
        end
      end
      ACT_UPDATE: begin
        if (hit_r) begin
          res_status = STAT_OK;
          res_slot   = hit_idx_ext[SLOT_OUT_W-1:0];
          res_ident  = hit_ident_r;
          res_cat    = cat_r;
          ram_we     = 1'b1;
          ram_wdata  = {cat_r, hit_ident_r};
        end
      end
      ACT_REMOVE: begin
        if (hit_r) begin
          res_status = STAT_OK;
          res_slot   = hit_idx_ext[SLOT_OUT_W-1:0];
          res_ident  = hit_ident_r;
          res_cat    = hit_cat_r;
          ram_we     = 1'b1;
          ram_wdata  = '0;
          used_nxt[hit_idx_r] = 1'b0;
        end
      end
      default: begin
        res_status = STAT_FAIL;
      end
    endcase
    if (!cmd.finish) begin
      ram_we   = 1'b0;
      used_nxt = used_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      ctr_r     <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
      if (cmd.finish && (op_r == ACT_ALLOC) && hit_r) begin
        ctr_r <= ctr_inc;
      end
      if (cmd.start) begin
        cmp_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r      <= in_act;
      key_r     <= in_tdata[ACT_W +: KEY_W];
      cat_r     <= in_tdata[ACT_W+KEY_W +: CAT_W];
      iss_idx_r <= '0;
      hit_r     <= 1'b0;
    end else if (cmd.scan) begin
      cmp_idx_r <= iss_idx_r;
      if (iss_idx_r != LAST_SLOT) begin
        iss_idx_r <= iss_idx_r + SLOT_W'(1);
      end
      if (scan_end) begin
        hit_r       <= match;
        hit_idx_r   <= cmp_idx_r;
        hit_ident_r <= rd_ident;
        hit_cat_r   <= rd_cat;
      end
    end
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_ident_r  <= res_ident;
      out_cat_r    <= res_cat;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_cat_r, out_ident_r, out_slot_r, out_status_r};

endmodule

### tb/keyed_slot_table_core_tb.sv
// Self-checking testbench for keyed_slot_table_core: stream driver, monitor and table predictor.
module keyed_slot_table_core_tb;
  import kst_pkg::*;

  // Action codes outside the enum; the block must reject them
  localparam logic [ACT_W-1:0] ACT_BAD_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_BAD_HI = 3'd7;

  localparam int PAD_W         = IN_DATA_W - ACT_W - KEY_W - CAT_W;
  localparam int LONG_HOLD     = 300;         // receiver hold-off, in cycles
  localparam int TAIL_CYCLES   = SLOTS + 16;  // a full miss walk plus margin
  localparam int LIMIT         = 40_000_000;  // hard stop, in time units
  localparam int MAX_REPORTS   = 30;
  localparam int BURST_TRIPLES = 16;          // allocate/allocate/clear groups per burst

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic [CAT_W-1:0] category;
  } table_op_t;

  typedef struct packed {
    logic                  status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [ID_W-1:0]       ident;
    logic [CAT_W-1:0]      category;
  } table_res_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  keyed_slot_table_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predicted table contents, advanced once per accepted input transfer
  bit   [SLOTS-1:0] tbl_used = '0;
  logic [ID_W-1:0]  tbl_id  [SLOTS];
  logic [CAT_W-1:0] tbl_cat [SLOTS];
  logic [ID_W-1:0]  id_ctr = '0;

  table_op_t  op_q[$];          // items waiting for the driver
  table_res_t pending_res_q[$]; // predicted results, oldest first
  table_op_t  cur_op = '0;      // item currently offered on in_

  // Pacing state for the driver and the receiver
  int gap_left   = 0;
  int stall_left = 0;
  int idle_pct   = 0;
  bit quiet      = 1'b0;   // no idling at all, for the back-to-back burst
  bit hold_req   = 1'b0;   // toggled to ask the receiver for a long hold-off
  bit hold_seen  = 1'b0;
  bit in_taken   = 1'b0;   // input transfer at the last rising edge

  // Bookkeeping
  int n_pushed  = 0;
  int n_in      = 0;
  int n_out     = 0;
  int n_gen     = 0;
  int err_cnt   = 0;
  int n_full    = 0;
  int n_wrap    = 0;
  int n_reject  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Lowest used slot whose id (or category) equals key; -1 if none.
  function automatic int lowest_match(bit by_cat, logic [KEY_W-1:0] key);
    int s;
    int hit;
    hit = -1;
    for (s = SLOTS - 1; s >= 0; s--)
      if (tbl_used[s] && ((by_cat ? tbl_cat[s] : tbl_id[s]) == key))
        hit = s;
    return hit;
  endfunction

  function automatic table_res_t apply_op(table_op_t op);
    table_res_t r;
    int         i;
    int         s;
    r        = '0;
    r.status = STAT_FAIL;
    i        = -1;
    case (op.action)
      ACT_CLEAR: begin
        // only the used marks go; ids, categories and the counter stay
        tbl_used = '0;
        r.status = STAT_OK;
      end
      ACT_ALLOC: begin
        for (s = SLOTS - 1; s >= 0; s--)
          if (!tbl_used[s])
            i = s;
        if (i < 0) begin
          n_full++;   // table full: counter must not move
        end else begin
          id_ctr++;
          if (id_ctr == '0)
            n_wrap++;
          tbl_used[i] = 1'b1;
          tbl_id[i]   = id_ctr;
          tbl_cat[i]  = op.category;
          r = {STAT_OK, SLOT_OUT_W'(i), id_ctr, op.category};
        end
      end
      ACT_FIND_ID, ACT_FIND_CAT: begin
        i = lowest_match(op.action == ACT_FIND_CAT, op.key);
        if (i >= 0)
          r = {STAT_OK, SLOT_OUT_W'(i), tbl_id[i], tbl_cat[i]};
      end
      ACT_UPDATE: begin
        i = lowest_match(1'b0, op.key);
        if (i >= 0) begin
          tbl_cat[i] = op.category;
          r = {STAT_OK, SLOT_OUT_W'(i), tbl_id[i], op.category};
        end
      end
      ACT_REMOVE: begin
        // result carries what the slot held before it was freed
        i = lowest_match(1'b0, op.key);
        if (i >= 0) begin
          r = {STAT_OK, SLOT_OUT_W'(i), tbl_id[i], tbl_cat[i]};
          tbl_used[i] = 1'b0;
          tbl_id[i]   = '0;
          tbl_cat[i]  = '0;
        end
      end
      default: ;
    endcase
    if (r.status == STAT_FAIL)
      n_reject++;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: new item or gap at the falling edge once the last one has gone
  // --------------------------------------------------------------------------

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  always @(negedge clk) begin : drive_in
    table_op_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (op_q.size() != 0) begin
        nxt       = op_q.pop_front();
        cur_op    <= nxt;
        in_tdata  <= {{PAD_W{1'b0}}, nxt.category, nxt.key, nxt.action};
        in_tvalid <= 1'b1;
        gap_left  <= (!quiet && $urandom_range(0, 99) < idle_pct) ? idle_len() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      stall_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= idle_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each result transfer
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : watch
    table_res_t got;
    table_res_t exp_res;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      pending_res_q.push_back(apply_op(cur_op));
      n_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      got.status   = out_tdata[0];
      got.slot     = out_tdata[6:1];
      got.ident    = out_tdata[22:7];
      got.category = out_tdata[38:23];
      if (pending_res_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result: status %0d slot %0d ident %h category %h",
                   $time, got.status, got.slot, got.ident, got.category);
      end else begin
        exp_res = pending_res_q.pop_front();
        if (got !== exp_res) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result %0d: expected status %0d slot %0d ident %h category %h, %s",
                     $time, n_out, exp_res.status, exp_res.slot, exp_res.ident,
                     exp_res.category,
                     $sformatf("got status %0d slot %0d ident %h category %h",
                               got.status, got.slot, got.ident, got.category));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic push_op(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                         logic [CAT_W-1:0] cat);
    op_q.push_back({act, key, cat});
    n_pushed++;
  endtask

  // Mostly keys that are live in the table, so that lookups hit
  function automatic logic [KEY_W-1:0] pick_key(bit by_cat);
    int s;
    int k;
    if ($urandom_range(0, 99) < 80 && tbl_used != '0) begin
      s = $urandom_range(0, SLOTS - 1);
      for (k = 0; k < SLOTS; k++)
        if (!tbl_used[s])
          s = (s + 1) % SLOTS;
      return by_cat ? tbl_cat[s] : tbl_id[s];
    end
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return id_ctr - KEY_W'($urandom_range(0, 8));  // current or stale ids
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Small categories give duplicates, so lowest-match order gets exercised
  function automatic logic [CAT_W-1:0] pick_cat();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CAT_W'($urandom_range(0, 3));
      4:          return '0;
      5:          return '1;
      default:    return CAT_W'($urandom);
    endcase
  endfunction

  task automatic push_random();
    int               r;
    logic [ACT_W-1:0] act;
    r = $urandom_range(0, 99);
    if (r < 30)      act = ACT_ALLOC;
    else if (r < 50) act = ACT_FIND_ID;
    else if (r < 63) act = ACT_FIND_CAT;
    else if (r < 78) act = ACT_UPDATE;
    else if (r < 95) act = ACT_REMOVE;
    else if (r < 97) act = ACT_CLEAR;
    else             act = $urandom_range(0, 1) ? ACT_BAD_HI : ACT_BAD_LO;
    push_op(act, pick_key(act == ACT_FIND_CAT), pick_cat());
    n_gen++;
  endtask

  // Sender pause: hold back until every transfer has its result back
  task automatic drain_all();
    while (n_in != n_pushed || pending_res_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic rand_run(int n);
    repeat (n) begin
      if (n_gen % 100 == 0)
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 10;
          2: idle_pct = 30;
          default: idle_pct = 60;
        endcase
      while (op_q.size() >= 4)
        @(negedge clk);
      push_random();
    end
  endtask

  // Fill every free slot, then a few more allocations to hit table full
  task automatic fill_table();
    int n;
    drain_all();
    n = SLOTS - $countones(tbl_used) + $urandom_range(1, 3);
    repeat (n)
      push_op(ACT_ALLOC, KEY_W'($urandom), pick_cat());
    n_gen += n;
  endtask

  // Long receiver hold-off with the sender still offering: input must stall
  task automatic long_hold();
    idle_pct = 0;
    hold_req = ~hold_req;
    repeat (12)
      push_random();
    do
      @(negedge clk);
    while (hold_seen != hold_req || stall_left != 0);
  endtask

  // Short burst of allocate/allocate/clear triples with no idling on either side
  task automatic counter_bulk();
    drain_all();
    quiet = 1'b1;
    push_op(ACT_CLEAR, '0, '0);
    repeat (BURST_TRIPLES) begin
      push_op(ACT_ALLOC, KEY_W'($urandom), CAT_W'($urandom));
      push_op(ACT_ALLOC, KEY_W'($urandom), CAT_W'($urandom));
      push_op(ACT_CLEAR, KEY_W'($urandom), CAT_W'($urandom));
    end
    drain_all();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-table misses (stored ids are never written and unused), bad actions,
    // first allocations, duplicate categories, update, remove and slot reuse, clear
    push_op(ACT_FIND_ID,  16'h0000, 16'h0000);
    push_op(ACT_FIND_CAT, 16'h0000, 16'h0000);
    push_op(ACT_UPDATE,   16'h0000, 16'hFFFF);
    push_op(ACT_REMOVE,   16'h0000, 16'h0000);
    push_op(ACT_BAD_LO,   16'hFFFF, 16'hFFFF);
    push_op(ACT_BAD_HI,   16'hFFFF, 16'hFFFF);
    push_op(ACT_ALLOC,    16'hFFFF, 16'hFFFF);
    push_op(ACT_ALLOC,    16'h0000, 16'h0000);
    push_op(ACT_ALLOC,    16'h5555, 16'h8000);
    push_op(ACT_ALLOC,    16'hAAAA, 16'h0000);
    push_op(ACT_FIND_ID,  16'h0002, 16'h0000);
    push_op(ACT_FIND_CAT, 16'h0000, 16'h0000);
    push_op(ACT_FIND_CAT, 16'hFFFF, 16'h0000);
    push_op(ACT_UPDATE,   16'h0003, 16'h1234);
    push_op(ACT_FIND_CAT, 16'h1234, 16'h0000);
    push_op(ACT_REMOVE,   16'h0001, 16'h0000);
    push_op(ACT_FIND_ID,  16'h0001, 16'h0000);
    push_op(ACT_ALLOC,    16'h0000, 16'h0007);
    push_op(ACT_FIND_ID,  16'hFFFF, 16'h0000);
    push_op(ACT_CLEAR,    16'hFFFF, 16'hFFFF);
    push_op(ACT_FIND_ID,  16'h0002, 16'h0000);
    push_op(ACT_ALLOC,    16'h0000, 16'hAAAA);
    drain_all();

    // Random, well-formed mostly, with the pressure phases in between
    rand_run(300);
    fill_table();
    rand_run(300);
    long_hold();
    rand_run(200);
    counter_bulk();
    fill_table();
    rand_run(700);

    drain_all();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run: %0d input transfers, %0d results checked, %0d mismatching",
             n_in, n_out, err_cnt);
    $display("Covered: %0d table-full rejects, %0d id wraps, %0d failed actions in all",
             n_full, n_wrap, n_reject);
    if (err_cnt == 0 && pending_res_q.size() == 0)
      $display("keyed_slot_table_core_tb: clean");
    else
      $display("keyed_slot_table_core_tb: errors");
    $finish;
  end

  initial begin
    #(LIMIT);
    $display("%0t: timeout, %0d results still outstanding", $time, pending_res_q.size());
    $display("keyed_slot_table_core_tb: errors");
    $finish;
  end

endmodule
